FILE: rtl/motion_supervisor_with_command_timeout_assert.svh
// assertion macros used by the checker of the motion supervisor
`ifndef MOTION_SUPERVISOR_WITH_COMMAND_TIMEOUT_ASSERT_SVH
`define MOTION_SUPERVISOR_WITH_COMMAND_TIMEOUT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MSUP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MSUP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/msup_pkg.sv
package msup_pkg;

  localparam int ValW       = 32;
  localparam int GainW      = 16;
  localparam int GainFrac   = 8;
  localparam int AgeW       = 16;
  localparam int ThrW       = 16;
  localparam int CmdW       = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int SumW       = ValW + 1;
  localparam int ProdW      = SumW + GainW + 1;
  localparam int InDataW    = 104;
  localparam int OutDataW   = 40;
  localparam int QueueDepth = 2;
  localparam int QueueCntW  = 2;

  localparam logic [AgeW-1:0] AgeMax = '1;

  localparam logic [CmdW-1:0] CmdRecenter = 3'd0;
  localparam logic [CmdW-1:0] CmdAccel    = 3'd1;
  localparam logic [CmdW-1:0] CmdVel      = 3'd2;

  localparam logic [AgeW-1:0] TimeoutReset  = 16'd100;
  localparam logic [ThrW-1:0] PosThrReset   = 16'd164;
  localparam logic [ThrW-1:0] VelThrReset   = 16'd1638;
  localparam logic [ThrW-1:0] IdleThrReset  = 16'd1311;
  localparam logic [GainW-1:0] RecGainReset = 16'd3840;
  localparam logic [GainW-1:0] DampGainReset = 16'd3840;

  typedef enum logic [2:0] {
    MODE_EXEC     = 3'd0,
    MODE_RECENTER = 3'd1,
    MODE_IDLE     = 3'd2,
    MODE_TERM     = 3'd3,
    MODE_HALT     = 3'd4
  } op_mode_t;

  typedef enum logic [1:0] {
    DRIVE_NONE  = 2'd0,
    DRIVE_ACCEL = 2'd1,
    DRIVE_VEL   = 2'd2
  } drive_mode_t;

  typedef enum logic [1:0] {
    KIND_RECENTER = 2'd0,
    KIND_ACCEL    = 2'd1,
    KIND_VEL      = 2'd2,
    KIND_TERM     = 2'd3
  } cmd_kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT   = 3'd0,
    REG_POS_THR   = 3'd1,
    REG_VEL_THR   = 3'd2,
    REG_IDLE_THR  = 3'd3,
    REG_REC_GAIN  = 3'd4,
    REG_DAMP_GAIN = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ValW-1:0] vel;
    logic [ValW-1:0]        abs_pos;
    logic [ValW-1:0]        abs_vel;
    logic signed [SumW-1:0] sum;
    logic                   new_cmd;
    cmd_kind_t              kind;
    logic signed [ValW-1:0] cmd_value;
  } tick_t;

  typedef struct packed {
    drive_mode_t            dmode;
    logic                   use_gain;
    op_mode_t               mode;
    logic                   tout;
    logic signed [ValW-1:0] value;
  } ctl_t;

  // last field in the lowest bits
  typedef struct packed {
    logic                   done_res;
    logic                   timed_out;
    op_mode_t               mode_out;
    logic signed [ValW-1:0] drive_value;
    drive_mode_t            drive_mode;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage

FILE: rtl/msup_front.sv
module msup_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // motor_pos, motor_vel, cmd, cmd_value
  input  logic [msup_pkg::InDataW-1:0] s_tdata,
  // new_cmd
  input  logic                         s_tuser,
  output logic                         q_valid,
  input  logic                         q_ready,
  output msup_pkg::tick_t              q_tick
);

  logic signed [msup_pkg::ValW-1:0] pos;
  logic signed [msup_pkg::ValW-1:0] vel;
  logic [msup_pkg::CmdW-1:0]        cmd_code;
  msup_pkg::tick_t                  tick_c;
  msup_pkg::tick_t                  mem [msup_pkg::QueueDepth];
  logic                             wr_ptr;
  logic                             rd_ptr;
  logic [msup_pkg::QueueCntW-1:0]   count;
  logic                             push;
  logic                             pop;

  assign pos      = s_tdata[31:0];
  assign vel      = s_tdata[63:32];
  assign cmd_code = s_tdata[66:64];

  always_comb begin
    tick_c.vel       = vel;
    tick_c.abs_pos   = pos[msup_pkg::ValW-1] ? -pos : pos;
    tick_c.abs_vel   = vel[msup_pkg::ValW-1] ? -vel : vel;
    tick_c.sum       = msup_pkg::SumW'(pos) + msup_pkg::SumW'(vel);
    tick_c.new_cmd   = s_tuser;
    tick_c.cmd_value = s_tdata[98:67];
    unique case (cmd_code)
      msup_pkg::CmdRecenter: tick_c.kind = msup_pkg::KIND_RECENTER;
      msup_pkg::CmdAccel:    tick_c.kind = msup_pkg::KIND_ACCEL;
      msup_pkg::CmdVel:      tick_c.kind = msup_pkg::KIND_VEL;
      default:               tick_c.kind = msup_pkg::KIND_TERM;
    endcase
  end

  assign s_tready = (count != msup_pkg::QueueCntW'(msup_pkg::QueueDepth));
  assign q_valid  = (count != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;
  assign q_tick   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + msup_pkg::QueueCntW'(push) - msup_pkg::QueueCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= tick_c;
    end
  end

endmodule

FILE: rtl/msup_back.sv
module msup_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [msup_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [msup_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  msup_pkg::tick_t               q_tick,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [msup_pkg::OutDataW-1:0] m_tdata
);

  logic [msup_pkg::AgeW-1:0]  timeout_ticks;
  logic [msup_pkg::ThrW-1:0]  pos_threshold;
  logic [msup_pkg::ThrW-1:0]  vel_threshold;
  logic [msup_pkg::ThrW-1:0]  idle_vel_threshold;
  logic [msup_pkg::GainW-1:0] recenter_gain;
  logic [msup_pkg::GainW-1:0] damping_gain;

  msup_pkg::op_mode_t               op_mode;
  msup_pkg::op_mode_t               mode_mid;
  msup_pkg::op_mode_t               op_mode_next;
  msup_pkg::cmd_kind_t              held_kind;
  msup_pkg::cmd_kind_t              kind_eff;
  logic signed [msup_pkg::ValW-1:0] held_value;
  logic signed [msup_pkg::ValW-1:0] value_eff;
  logic [msup_pkg::AgeW-1:0]        command_age;
  logic [msup_pkg::AgeW-1:0]        age_eff;
  logic                             first_tick;
  logic                             tout_c;
  logic                             near;
  logic                             idle_slow;

  msup_pkg::ctl_t                    ctl_c;
  logic signed [msup_pkg::SumW-1:0]  operand_c;
  logic [msup_pkg::GainW-1:0]        gain_c;
  logic                              en;
  logic                              pop;

  logic                              s1_valid;
  msup_pkg::ctl_t                    s1_ctl;
  logic signed [msup_pkg::SumW-1:0]  s1_operand;
  logic [msup_pkg::GainW-1:0]        s1_gain;
  logic                              s2_valid;
  msup_pkg::ctl_t                    s2_ctl;
  logic signed [msup_pkg::ProdW-1:0] s2_prod;
  logic signed [msup_pkg::ProdW-1:0] prod_c;
  logic signed [msup_pkg::ProdW-1:0] neg_c;
  logic signed [msup_pkg::ProdW-1:0] quo_c;
  logic signed [msup_pkg::ValW-1:0]  sat_c;
  msup_pkg::result_t                 res_c;
  msup_pkg::result_t                 res;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks      <= msup_pkg::TimeoutReset;
      pos_threshold      <= msup_pkg::PosThrReset;
      vel_threshold      <= msup_pkg::VelThrReset;
      idle_vel_threshold <= msup_pkg::IdleThrReset;
      recenter_gain      <= msup_pkg::RecGainReset;
      damping_gain       <= msup_pkg::DampGainReset;
    end else if (cfg_we) begin
      unique case (msup_pkg::cfg_reg_t'(cfg_index))
        msup_pkg::REG_TIMEOUT:   timeout_ticks      <= cfg_data;
        msup_pkg::REG_POS_THR:   pos_threshold      <= cfg_data;
        msup_pkg::REG_VEL_THR:   vel_threshold      <= cfg_data;
        msup_pkg::REG_IDLE_THR:  idle_vel_threshold <= cfg_data;
        msup_pkg::REG_REC_GAIN:  recenter_gain      <= cfg_data;
        msup_pkg::REG_DAMP_GAIN: damping_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en      = !m_tvalid || m_tready;
  assign q_ready = en;
  assign pop     = q_valid && en;

  // command update and stale-command check
  always_comb begin
    kind_eff  = q_tick.new_cmd ? q_tick.kind : held_kind;
    value_eff = q_tick.new_cmd ? q_tick.cmd_value : held_value;
    age_eff   = q_tick.new_cmd ? '0 : command_age;
    mode_mid  = op_mode;
    tout_c    = 1'b0;
    if (op_mode == msup_pkg::MODE_EXEC || op_mode == msup_pkg::MODE_IDLE) begin
      if (age_eff > timeout_ticks && op_mode != msup_pkg::MODE_IDLE && !first_tick) begin
        mode_mid = msup_pkg::MODE_IDLE;
        tout_c   = 1'b1;
      end
      if (age_eff < timeout_ticks) begin
        mode_mid = msup_pkg::MODE_EXEC;
      end
    end
    near = (q_tick.abs_vel < msup_pkg::ValW'(vel_threshold)) &&
           (q_tick.abs_pos < msup_pkg::ValW'(pos_threshold));
    idle_slow = (q_tick.abs_vel < msup_pkg::ValW'(idle_vel_threshold));
  end

  always_comb begin
    op_mode_next = mode_mid;
    unique case (mode_mid)
      msup_pkg::MODE_EXEC: begin
        if (kind_eff == msup_pkg::KIND_RECENTER) begin
          op_mode_next = msup_pkg::MODE_RECENTER;
        end else if (kind_eff == msup_pkg::KIND_TERM) begin
          op_mode_next = msup_pkg::MODE_TERM;
        end
      end
      msup_pkg::MODE_IDLE, msup_pkg::MODE_HALT: op_mode_next = mode_mid;
      msup_pkg::MODE_RECENTER: begin
        if (near) begin
          op_mode_next = msup_pkg::MODE_IDLE;
        end
      end
      default: op_mode_next = near ? msup_pkg::MODE_HALT : msup_pkg::MODE_TERM;
    endcase
  end

  always_comb begin
    ctl_c.dmode    = msup_pkg::DRIVE_NONE;
    ctl_c.use_gain = 1'b0;
    ctl_c.mode     = op_mode_next;
    ctl_c.tout     = tout_c;
    ctl_c.value    = '0;
    operand_c      = q_tick.sum;
    gain_c         = recenter_gain;
    unique case (mode_mid)
      msup_pkg::MODE_EXEC: begin
        if (kind_eff == msup_pkg::KIND_ACCEL) begin
          ctl_c.dmode = msup_pkg::DRIVE_ACCEL;
          ctl_c.value = value_eff;
        end else if (kind_eff == msup_pkg::KIND_VEL) begin
          ctl_c.dmode = msup_pkg::DRIVE_VEL;
          ctl_c.value = value_eff;
        end
      end
      msup_pkg::MODE_IDLE: begin
        if (idle_slow) begin
          ctl_c.dmode = msup_pkg::DRIVE_VEL;
        end else begin
          ctl_c.dmode    = msup_pkg::DRIVE_ACCEL;
          ctl_c.use_gain = 1'b1;
          operand_c      = msup_pkg::SumW'(q_tick.vel);
          gain_c         = damping_gain;
        end
      end
      msup_pkg::MODE_HALT: ctl_c.dmode = msup_pkg::DRIVE_NONE;
      default: begin
        if (near) begin
          ctl_c.dmode = msup_pkg::DRIVE_VEL;
        end else begin
          ctl_c.dmode    = msup_pkg::DRIVE_ACCEL;
          ctl_c.use_gain = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode     <= msup_pkg::MODE_EXEC;
      held_kind   <= msup_pkg::KIND_ACCEL;
      held_value  <= '0;
      command_age <= '0;
      first_tick  <= 1'b1;
    end else if (pop) begin
      op_mode     <= op_mode_next;
      held_kind   <= kind_eff;
      held_value  <= value_eff;
      command_age <= (age_eff == msup_pkg::AgeMax) ? age_eff : age_eff + 1'b1;
      first_tick  <= 1'b0;
    end
  end

  // product, then floor of the negated product over 256 with saturation
  assign prod_c = s1_operand * $signed({1'b0, s1_gain});
  assign neg_c  = -s2_prod;
  assign quo_c  = neg_c >>> msup_pkg::GainFrac;

  always_comb begin
    if ((&quo_c[msup_pkg::ProdW-1:msup_pkg::ValW-1]) ||
        !(|quo_c[msup_pkg::ProdW-1:msup_pkg::ValW-1])) begin
      sat_c = quo_c[msup_pkg::ValW-1:0];
    end else if (quo_c[msup_pkg::ProdW-1]) begin
      sat_c = {1'b1, {(msup_pkg::ValW-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(msup_pkg::ValW-1){1'b1}}};
    end
    res_c.drive_mode  = s2_ctl.dmode;
    res_c.drive_value = s2_ctl.use_gain ? sat_c : s2_ctl.value;
    res_c.mode_out    = s2_ctl.mode;
    res_c.timed_out   = s2_ctl.tout;
    res_c.done_res    = (s2_ctl.mode == msup_pkg::MODE_HALT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid <= pop;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl     <= ctl_c;
      s1_operand <= operand_c;
      s1_gain    <= gain_c;
      s2_ctl     <= s1_ctl;
      s2_prod    <= prod_c;
      res        <= res_c;
    end
  end

  assign m_tdata = msup_pkg::OutDataW'(res);

endmodule

FILE: rtl/motion_supervisor_with_command_timeout.sv
// Motion supervisor: each input word is one control tick (position, velocity and an optional
// fresh command in s_tuser) and gives exactly one output word with the drive request, the mode
// after the tick, the timeout flag and the done flag. The block sustains one word per cycle
// while the receiver does not stall: a two-word input queue feeds a back end whose first stage
// updates mode, held command and command age, whose second stage holds the 33 x 17 bit gain
// multiply, and whose third stage floors, saturates and registers the result. Configuration
// writes take effect on the next cycle.
module motion_supervisor_with_command_timeout (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [msup_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [msup_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // motor_pos, motor_vel, cmd, cmd_value, zero fill
  input  logic [msup_pkg::InDataW-1:0]  s_tdata,
  // new_cmd
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // drive_mode, drive_value, mode_out, timed_out, done_res, zero fill
  output logic [msup_pkg::OutDataW-1:0] m_tdata
);

  logic            q_valid;
  logic            q_ready;
  msup_pkg::tick_t q_tick;

  msup_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_tick   (q_tick)
  );

  msup_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_tick    (q_tick),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: rtl/msup_checker.sv
`include "motion_supervisor_with_command_timeout_assert.svh"

module msup_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [msup_pkg::OutDataW-1:0] m_tdata
);

  msup_pkg::result_t res;

  assign res = msup_pkg::result_t'(m_tdata[msup_pkg::ResultW-1:0]);

  `MSUP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `MSUP_ASSERT_NOW(a_no_drive_zero, m_tvalid && res.drive_mode == msup_pkg::DRIVE_NONE, res.drive_value == '0, "no-drive word with nonzero value")
  `MSUP_ASSERT_NOW(a_done_halt, m_tvalid, res.done_res == (res.mode_out == msup_pkg::MODE_HALT), "done flag disagrees with halted mode")
  `MSUP_ASSERT_NOW(a_timeout_idle, m_tvalid && res.timed_out, res.mode_out == msup_pkg::MODE_IDLE && res.drive_mode != msup_pkg::DRIVE_NONE, "timeout word not in idle")

endmodule

bind motion_supervisor_with_command_timeout msup_checker u_msup_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import msup_pkg::*;

  localparam logic [CmdW-1:0] CmdTerm = 3'd3;
  localparam int StuckLimit = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [OutDataW-1:0] m_tdata;

  always #10 clk = ~clk;

  motion_supervisor_with_command_timeout uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // predicted supervisor state and register copies
  op_mode_t sup_mode = MODE_EXEC;
  logic [CmdW-1:0] held_code = CmdAccel;
  logic signed [ValW-1:0] held_operand = '0;
  logic [AgeW-1:0] cmd_age = '0;
  logic first_tick = 1'b1;
  logic [15:0] cfg_timeout = TimeoutReset;
  logic [15:0] cfg_pos_thr = PosThrReset;
  logic [15:0] cfg_vel_thr = VelThrReset;
  logic [15:0] cfg_idle_thr = IdleThrReset;
  logic [15:0] cfg_rec_gain = RecGainReset;
  logic [15:0] cfg_damp_gain = DampGainReset;

  result_t awaited_requests[$];
  int ticks_sent = 0;
  int results_checked = 0;
  int timeouts_seen = 0;
  int settings_applied = 0;
  int failures = 0;
  int stuck_cycles = 0;
  int hold_cycles = 0;
  int stall_left = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  logic [4:0] modes_seen = '0;

  // floor(-(g * s) / 256), saturated to the value width
  function automatic logic signed [ValW-1:0] gain_pull(longint s, logic [15:0] g);
    longint n;
    n = -(s * longint'(g));
    n = n >>> GainFrac;
    if (n > 64'sd2147483647) return 32'sh7fff_ffff;
    if (n < -64'sd2147483648) return 32'sh8000_0000;
    return n[ValW-1:0];
  endfunction

  function automatic result_t supervise_tick(logic signed [ValW-1:0] pos,
                                             logic signed [ValW-1:0] vel, logic fresh,
                                             logic [CmdW-1:0] code,
                                             logic signed [ValW-1:0] operand);
    result_t r;
    longint p, v, abs_p, abs_v;
    logic near;
    r = '0;
    r.drive_mode = DRIVE_NONE;
    p = pos;
    v = vel;
    abs_p = (p < 0) ? -p : p;
    abs_v = (v < 0) ? -v : v;
    if (fresh) begin
      held_code = code;
      held_operand = operand;
      cmd_age = '0;
    end
    if (sup_mode == MODE_EXEC || sup_mode == MODE_IDLE) begin
      if (cmd_age > cfg_timeout && sup_mode != MODE_IDLE && !first_tick) begin
        sup_mode = MODE_IDLE;
        r.timed_out = 1'b1;
      end
      if (cmd_age < cfg_timeout) sup_mode = MODE_EXEC;
    end
    near = abs_v < longint'(cfg_vel_thr) && abs_p < longint'(cfg_pos_thr);
    case (sup_mode)
      MODE_EXEC: begin
        if (held_code == CmdRecenter) begin
          sup_mode = MODE_RECENTER;
        end else if (held_code == CmdAccel) begin
          r.drive_mode = DRIVE_ACCEL;
          r.drive_value = held_operand;
        end else if (held_code == CmdVel) begin
          r.drive_mode = DRIVE_VEL;
          r.drive_value = held_operand;
        end else begin
          sup_mode = MODE_TERM;
        end
      end
      MODE_IDLE: begin
        if (abs_v < longint'(cfg_idle_thr)) begin
          r.drive_mode = DRIVE_VEL;
        end else begin
          r.drive_mode = DRIVE_ACCEL;
          r.drive_value = gain_pull(v, cfg_damp_gain);
        end
      end
      MODE_HALT: ;
      default: begin
        if (near) begin
          r.drive_mode = DRIVE_VEL;
          sup_mode = (sup_mode == MODE_RECENTER) ? MODE_IDLE : MODE_HALT;
        end else begin
          r.drive_mode = DRIVE_ACCEL;
          r.drive_value = gain_pull(p + v, cfg_rec_gain);
          if (sup_mode != MODE_RECENTER) sup_mode = MODE_TERM;
        end
      end
    endcase
    if (cmd_age != AgeMax) cmd_age = cmd_age + 1'b1;
    first_tick = 1'b0;
    r.mode_out = sup_mode;
    r.done_res = (sup_mode == MODE_HALT);
    return r;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_tick(logic signed [ValW-1:0] pos, logic signed [ValW-1:0] vel,
                           logic fresh, logic [CmdW-1:0] code,
                           logic signed [ValW-1:0] operand);
    if (!sender_steady && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tdata = {5'b0, operand, code, vel, pos};
    s_tuser = fresh;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    awaited_requests.push_back(supervise_tick(pos, vel, fresh, code, operand));
    ticks_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    while (awaited_requests.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TIMEOUT: cfg_timeout = data;
      REG_POS_THR: cfg_pos_thr = data;
      REG_VEL_THR: cfg_vel_thr = data;
      REG_IDLE_THR: cfg_idle_thr = data;
      REG_REC_GAIN: cfg_rec_gain = data;
      REG_DAMP_GAIN: cfg_damp_gain = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] tmo, logic [15:0] pthr, logic [15:0] vthr,
                               logic [15:0] ithr, logic [15:0] rgain, logic [15:0] dgain);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_POS_THR, pthr);
    write_reg(REG_VEL_THR, vthr);
    write_reg(REG_IDLE_THR, ithr);
    write_reg(REG_REC_GAIN, rgain);
    write_reg(REG_DAMP_GAIN, dgain);
    settings_applied++;
  endtask

  // leaves recenter (if both thresholds are nonzero) and holds an accelerate command
  task automatic bring_to_rest();
    send_tick(0, 0, 1'b1, CmdAccel, $urandom);
  endtask

  function automatic logic signed [ValW-1:0] pick_signal(logic [15:0] bound);
    int unsigned kind;
    logic signed [ValW-1:0] mag;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      mag = (bound == 0) ? 0 : $urandom_range(0, bound - 1);
    end else if (kind <= 4) begin
      mag = $urandom_range(0, 70000);
    end else if (kind <= 7) begin
      mag = $urandom_range(0, 1 << 20);
    end else if (kind == 8) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return -1;
        default: return 1;
      endcase
    end else begin
      return $urandom;
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic random_tick();
    logic signed [ValW-1:0] pos, vel, operand;
    logic fresh;
    logic [CmdW-1:0] code, next_code;
    longint abs_p, abs_v;
    bit can_center;
    can_center = cfg_pos_thr != 0 && cfg_vel_thr != 0;
    pos = pick_signal(cfg_pos_thr);
    vel = pick_signal(sup_mode == MODE_RECENTER ? cfg_vel_thr : cfg_idle_thr);
    operand = $urandom_range(0, 15) == 0 ? pick_signal(16'hffff) : $urandom;
    fresh = $urandom_range(0, 6) == 0;
    code = $urandom_range(0, 7);
    if (fresh && sup_mode != MODE_RECENTER)
      code = can_center ? $urandom_range(CmdRecenter, CmdVel) : $urandom_range(CmdAccel, CmdVel);
    next_code = fresh ? code : held_code;
    abs_p = pos;
    abs_v = vel;
    if (abs_p < 0) abs_p = -abs_p;
    if (abs_v < 0) abs_v = -abs_v;
    // leaving recenter with a stop command held would end the run early
    if (sup_mode == MODE_RECENTER && next_code >= CmdTerm &&
        abs_p < longint'(cfg_pos_thr) && abs_v < longint'(cfg_vel_thr)) begin
      fresh = 1'b1;
      code = $urandom_range(CmdAccel, CmdVel);
    end
    send_tick(pos, vel, fresh, code, operand);
  endtask

  task automatic test_directed_extremes();
    send_tick(0, 0, 1'b0, 3'd7, 0);
    send_tick(32'sh8000_0000, 32'sh7fff_ffff, 1'b1, CmdAccel, 32'sh7fff_ffff);
    send_tick(32'sh7fff_ffff, 32'sh8000_0000, 1'b1, CmdVel, 32'sh8000_0000);
    send_tick(-1, 1, 1'b1, CmdVel, -1);
    send_tick(1 << 24, 0, 1'b1, CmdRecenter, 0);
    send_tick(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, CmdAccel, 0);
    send_tick(32'sh8000_0000, 32'sh8000_0000, 1'b0, CmdAccel, 0);
    send_tick(-65536, 0, 1'b1, 3'd6, 0);
    send_tick(10, -10, 1'b1, CmdVel, 12345);
    send_tick(0, 0, 1'b0, CmdRecenter, 0);
  endtask

  task automatic test_idle_and_timeout();
    write_reg(REG_TIMEOUT, 16'd3);
    write_reg(REG_DAMP_GAIN, 16'hffff);
    send_tick(0, 0, 1'b1, CmdAccel, 65536);
    repeat (3) send_tick(0, 0, 1'b0, CmdAccel, 0);
    send_tick(0, 32'sh8000_0000, 1'b0, CmdAccel, 0);
    send_tick(0, 1310, 1'b0, CmdAccel, 0);
    send_tick(0, -1311, 1'b0, CmdAccel, 0);
    write_reg(REG_DAMP_GAIN, 16'd1);
    write_reg(REG_REC_GAIN, 16'd257);
    send_tick(0, 1500, 1'b0, CmdAccel, 0);
    send_tick(0, -300000, 1'b0, CmdAccel, 0);
    send_tick(1000, 3, 1'b1, CmdRecenter, 0);
    send_tick(1000, 3, 1'b0, CmdRecenter, 0);
    send_tick(0, 0, 1'b0, CmdRecenter, 0);
    // stale at every age above zero, and writes to unused indexes change nothing
    write_reg(REG_TIMEOUT, 16'd0);
    for (int i = REG_DAMP_GAIN + 1; i < 8; i++) write_reg(i, 16'hffff);
    send_tick(0, 0, 1'b1, CmdVel, 7);
    send_tick(0, 5000, 1'b0, CmdVel, 0);
  endtask

  task automatic test_config_sweep();
    for (int phase = 0; phase < 6; phase++) begin
      bring_to_rest();
      case (phase)
        0: load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        2: load_settings(16'd5, 16'd164, 16'd1638, 16'd1311, 16'd257, 16'd1);
        3: load_settings($urandom_range(1, 30), $urandom, $urandom, $urandom, $urandom, $urandom);
        4: load_settings(16'd12, 16'd40000, 16'd30000, 16'd20000, 16'd3841, 16'd255);
        default: load_settings(16'd2, 16'd1, 16'd1, 16'hffff, 16'd1, 16'hfffe);
      endcase
      repeat (210) random_tick();
    end
  endtask

  task automatic test_input_backpressure();
    bring_to_rest();
    load_settings(16'd8, 16'd5000, 16'd5000, 16'd3000, 16'd600, 16'd900);
    sender_steady = 1'b1;
    hold_cycles = 300;
    repeat (40) random_tick();
    sender_steady = 1'b0;
  endtask

  task automatic test_terminate_and_halt();
    bring_to_rest();
    load_settings(TimeoutReset, PosThrReset, VelThrReset, IdleThrReset, RecGainReset,
                  DampGainReset);
    sender_steady = 1'b1;
    receiver_steady = 1'b1;
    repeat (100) random_tick();
    bring_to_rest();
    send_tick(1 << 20, 0, 1'b1, $urandom_range(CmdTerm, 7), $urandom);
    repeat (5) send_tick(pick_signal(16'hffff), $urandom, $urandom_range(0, 1),
                         $urandom_range(0, 7), $urandom);
    send_tick(0, 0, 1'b0, CmdAccel, 0);
    repeat (15) send_tick($urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 7),
                          $urandom);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      m_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (stall_left != 0) begin
      m_tready = 1'b0;
      stall_left = stall_left - 1;
    end else if (!receiver_steady && $urandom_range(0, 9) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[ResultW-1:0]);
      if (awaited_requests.size() == 0) begin
        $error("drive request word with none expected");
        failures++;
      end else begin
        want = awaited_requests.pop_front();
        results_checked++;
        if (got.timed_out) timeouts_seen++;
        if (got.mode_out <= MODE_HALT) modes_seen[got.mode_out] = 1'b1;
        if (got.drive_mode !== want.drive_mode) begin
          $error("drive_mode expected %0d got %0d", want.drive_mode, got.drive_mode);
          failures++;
        end
        if (got.drive_value !== want.drive_value) begin
          $error("drive_value expected %0d got %0d", want.drive_value, got.drive_value);
          failures++;
        end
        if (got.mode_out !== want.mode_out) begin
          $error("mode_out expected %0d got %0d", want.mode_out, got.mode_out);
          failures++;
        end
        if (got.timed_out !== want.timed_out) begin
          $error("timed_out expected %0d got %0d", want.timed_out, got.timed_out);
          failures++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res expected %0d got %0d", want.done_res, got.done_res);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_directed_extremes();
    test_idle_and_timeout();
    test_config_sweep();
    test_input_backpressure();
    test_terminate_and_halt();
    while (awaited_requests.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d control ticks driven, %0d drive requests compared, %0d timeouts seen",
             ticks_sent, results_checked, timeouts_seen);
    $display("tb: %0d register settings applied, modes reached (halt..exec) %b",
             settings_applied, modes_seen);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/msup_pkg.sv
rtl/msup_front.sv
rtl/msup_back.sv
rtl/motion_supervisor_with_command_timeout.sv
rtl/msup_checker.sv
sim/testbench.sv
